>>> hdl/lfpd_pkg.sv
// Shared types and constants for the length-field packet deframer.
package lfpd_pkg;

   localparam int WORD_W      = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_W-1:0] TRAILER_ONES = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_ACCEPT  = 3'd1,
      KIND_BAD_LEN = 3'd2,
      KIND_BAD_END = 3'd3,
      KIND_WAIT    = 3'd4
   } kind_type;

   // One classified request: an optional primary result plus an optional wait marker,
   // both carrying the same header words.
   typedef struct packed {
      logic              has_prim;
      kind_type          prim_kind;
      logic [7:0]        data;
      logic              wait_flag;
      logic [WORD_W-1:0] client_word;
      logic [WORD_W-1:0] type_word;
      logic [WORD_W-1:0] result_word;
      logic [WORD_W-1:0] length_word;
   } desc_type;

endpackage

>>> hdl/lfpd_front.sv
// Front end: frame parser that classifies each byte into a result descriptor.
module lfpd_front import lfpd_pkg::*; #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       chunk_end,
   output logic       push,
   output desc_type   desc
);

   localparam int LenW = $clog2(MAX_PAYLOAD + 1);
   localparam int CntW = (LenW > 4) ? LenW : 4;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_TRAILER = 2'd2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0] client_ff, type_ff, result_ff, length_ff, trailer_ff;
   logic [WORD_W-1:0] client_in, type_in, result_in, length_in, trailer_in;
   logic [WORD_W-1:0] client_w, type_w, result_w, length_w, trailer_w;
   logic [CntW:0]     cnt_inc;
   logic              frame_end;
   logic              len_bad;

   always_comb begin
      phase_in       = phase_ff;
      cnt_inc        = {1'b0, cnt_ff} + {{CntW{1'b0}}, 1'b1};
      cnt_in         = cnt_inc[CntW-1:0];
      client_w       = client_ff;
      type_w         = type_ff;
      result_w       = result_ff;
      length_w       = length_ff;
      trailer_w      = trailer_ff;
      frame_end      = 1'b0;
      len_bad        = 1'b0;
      desc.has_prim  = 1'b0;
      desc.prim_kind = KIND_PAYLOAD;
      desc.data      = 8'd0;

      unique case (phase_ff)
         PH_PAYLOAD: begin
            desc.has_prim = 1'b1;
            desc.data     = rx_byte;
            if (cnt_inc >= {1'b0, length_ff[CntW-1:0]}) begin
               phase_in = PH_TRAILER;
               cnt_in   = '0;
            end
         end
         PH_TRAILER: begin
            trailer_w = {trailer_ff[WORD_W-9:0], rx_byte};
            if (cnt_ff[1:0] == 2'd3) begin
               desc.has_prim  = 1'b1;
               desc.prim_kind = (trailer_w == TRAILER_ONES) ? KIND_ACCEPT : KIND_BAD_END;
               frame_end      = 1'b1;
            end
         end
         default: begin
            // header, or the unused phase code which restarts as a header
            unique case (cnt_ff[3:2])
               2'd0:    client_w = {client_ff[WORD_W-9:0], rx_byte};
               2'd1:    type_w   = {type_ff[WORD_W-9:0], rx_byte};
               2'd2:    result_w = {result_ff[WORD_W-9:0], rx_byte};
               default: length_w = {length_ff[WORD_W-9:0], rx_byte};
            endcase
            phase_in = PH_HEADER;
            if (cnt_ff[3:0] == 4'd15) begin
               len_bad = length_w[WORD_W-1] || (length_w > WORD_W'(MAX_PAYLOAD));
               cnt_in  = '0;
               if (len_bad) begin
                  desc.has_prim  = 1'b1;
                  desc.prim_kind = KIND_BAD_LEN;
                  frame_end      = 1'b1;
               end else begin
                  phase_in = (length_w == '0) ? PH_TRAILER : PH_PAYLOAD;
               end
            end
         end
      endcase

      if (frame_end) begin
         phase_in   = PH_HEADER;
         cnt_in     = '0;
         client_in  = '0;
         type_in    = '0;
         result_in  = '0;
         length_in  = '0;
         trailer_in = '0;
      end else begin
         client_in  = client_w;
         type_in    = type_w;
         result_in  = result_w;
         length_in  = length_w;
         trailer_in = trailer_w;
      end

      desc.wait_flag   = chunk_end && !frame_end;
      desc.client_word = client_w;
      desc.type_word   = type_w;
      desc.result_word = result_w;
      desc.length_word = length_w;
      push             = accept && (desc.has_prim || desc.wait_flag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         cnt_ff     <= '0;
         client_ff  <= '0;
         type_ff    <= '0;
         result_ff  <= '0;
         length_ff  <= '0;
         trailer_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         client_ff  <= client_in;
         type_ff    <= type_in;
         result_ff  <= result_in;
         length_ff  <= length_in;
         trailer_ff <= trailer_in;
      end
   end

endmodule

>>> hdl/lfpd_queue.sv
// Short descriptor queue between the parser and the result sequencer.
module lfpd_queue import lfpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head_desc,
   output logic     head_valid,
   output logic     full
);

   desc_type               mem [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ff, rd_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff;
   logic                   do_push, do_pop;

   assign full       = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_desc  = mem[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

>>> hdl/lfpd_back.sv
// Back end: expands each descriptor into one or two results in an output register.
module lfpd_back import lfpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  desc_type                 head_desc,
   input  logic                     head_valid,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_kind,
   output logic [7:0]               rsp_payload_byte,
   output logic signed [WORD_W-1:0] rsp_client_id,
   output logic signed [WORD_W-1:0] rsp_packet_type,
   output logic signed [WORD_W-1:0] rsp_packet_result,
   output logic signed [WORD_W-1:0] rsp_payload_length,
   output logic                     rsp_last_of_run
);

   logic              valid_ff;
   logic              second_ff, second_in;
   kind_type          kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in;
   logic [WORD_W-1:0] client_ff, type_ff, result_ff, length_ff;
   logic              last_ff, last_in;
   logic              load;

   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      second_in = second_ff;
      pop       = 1'b0;
      if (head_desc.has_prim && !second_ff) begin
         kind_in = head_desc.prim_kind;
         byte_in = head_desc.data;
         last_in = !head_desc.wait_flag;
      end else begin
         kind_in = KIND_WAIT;
         byte_in = 8'd0;
         last_in = 1'b1;
      end
      if (load && head_valid) begin
         pop       = last_in;
         second_in = !last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (load) begin
         valid_ff  <= head_valid;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         last_ff   <= last_in;
         client_ff <= head_desc.client_word;
         type_ff   <= head_desc.type_word;
         result_ff <= head_desc.result_word;
         length_ff <= head_desc.length_word;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_client_id      = $signed(client_ff);
   assign rsp_packet_type    = $signed(type_ff);
   assign rsp_packet_result  = $signed(result_ff);
   assign rsp_payload_length = $signed(length_ff);
   assign rsp_last_of_run    = last_ff;

endmodule

>>> hdl/length_field_packet_deframer.sv
// Length-field packet deframer: 16-byte header, payload bytes, 4-byte all-ones trailer.
// Throughput: one request per cycle while the queue is not full; the result side gives one
// result per cycle while rsp_stall is low, and a payload byte with a wait marker yields two.
// A result is written into the descriptor queue, then into the output register on rsp_valid.
// A 4-entry descriptor queue separates parser and result sequencer; req_stall is queue full.
// Reset (synchronous, active high) clears the parser to header collection and empties all.
module length_field_packet_deframer import lfpd_pkg::*; #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   input  logic                     req_chunk_end,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_kind,
   output logic [7:0]               rsp_payload_byte,
   output logic signed [WORD_W-1:0] rsp_client_id,
   output logic signed [WORD_W-1:0] rsp_packet_type,
   output logic signed [WORD_W-1:0] rsp_packet_result,
   output logic signed [WORD_W-1:0] rsp_payload_length,
   output logic                     rsp_last_of_run
);

   // front-end classification of the current request
   logic     accept;
   logic     push;
   desc_type push_desc;

   // queue head toward the sequencer
   desc_type head_desc;
   logic     head_valid;
   logic     pop;
   logic     full;

   // The parser never blocks on the result side directly; only a full queue stalls it.
   assign req_stall = full;
   assign accept    = req_valid && !full;

   lfpd_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .chunk_end (req_chunk_end),
      .push      (push),
      .desc      (push_desc)
   );

   // Requests that produce no result (header or trailer bytes that end no frame and carry no chunk_end) never enter.
   lfpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_desc  (head_desc),
      .head_valid (head_valid),
      .full       (full)
   );

   // The sequencer emits the primary result first, then the wait marker if flagged.
   lfpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_desc          (head_desc),
      .head_valid         (head_valid),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_client_id      (rsp_client_id),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_packet_result  (rsp_packet_result),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
